@@ rtl/sgdm_pkg.sv @@
`timescale 1ns / 1ps
package sgdm_pkg;

    localparam int PIPE_DEPTH = 8;
    localparam int CFG_IDX_W  = 3;

    localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
    localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
    localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] POS_INF     = 32'h7F80_0000;
    localparam logic [31:0] FP_ONE      = 32'h3F80_0000;
    localparam logic [15:0] BF16_NAN    = 16'h7FC0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOMENTUM  = 3'd0,
        REG_RATE      = 3'd1,
        REG_DECAY     = 3'd2,
        REG_DAMPENING = 3'd3,
        REG_NESTEROV  = 3'd4,
        REG_GRAD_FMT  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [31:0] param_bits;
        logic [31:0] grad_bits;
        logic [31:0] momentum_in;
    } sgdm_in_t;

    typedef struct packed {
        logic [31:0] new_param_bits;
        logic [31:0] new_momentum_bits;
        logic [15:0] param_bf16_copy;
    } sgdm_out_t;

    function automatic logic is_nan(input logic [31:0] a);
        return a[30:0] > POS_INF[30:0];
    endfunction

    function automatic logic is_inf(input logic [31:0] a);
        return a[30:0] == POS_INF[30:0];
    endfunction

    function automatic logic is_zero(input logic [31:0] a);
        return a[30:0] == 31'd0;
    endfunction

    function automatic logic [23:0] mant_of(input logic [31:0] a);
        return (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
    endfunction

    function automatic int exp_of(input logic [31:0] a);
        return (a[30:23] == 8'd0) ? -149 : int'(a[30:23]) - 150;
    endfunction

    function automatic logic [31:0] round_pack(input logic sign, input logic [63:0] m,
                                               input int e);
        int          p;
        int          big_e;
        int          shift;
        logic        normal;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        logic [63:0] bits;
        p = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (m[i])
                p = i;
        end
        big_e  = p + e + 127;
        normal = big_e >= 1;
        shift  = normal ? p - 23 : -149 - e;
        if (shift <= 0)
        begin
            q = m << (-shift);
        end
        else if (shift > 60)
        begin
            q = 64'd0;
        end
        else
        begin
            q    = m >> shift;
            rem  = m & ((64'd1 << shift) - 64'd1);
            half = 64'd1 << (shift - 1);
            if (rem > half || (rem == half && q[0]))
                q = q + 64'd1;
        end
        if (normal)
        begin
            bits = (64'(big_e - 1) << 23) + q;
            if (bits >= 64'(POS_INF))
                bits = 64'(POS_INF);
        end
        else
        begin
            bits = q;
        end
        return {sign, 31'd0} | bits[31:0];
    endfunction

    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic s;
        s = a[31] ^ b[31];
        if (is_nan(a))
            return a | QUIET_BIT;
        if (is_nan(b))
            return b | QUIET_BIT;
        if (is_inf(a) || is_inf(b))
        begin
            if (is_zero(a) || is_zero(b))
                return DEFAULT_NAN;
            return {s, 31'd0} | POS_INF;
        end
        if (is_zero(a) || is_zero(b))
            return {s, 31'd0};
        return round_pack(s, 64'(mant_of(a)) * 64'(mant_of(b)), exp_of(a) + exp_of(b));
    endfunction

    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
        logic        sa;
        logic        sb;
        logic [23:0] ma;
        logic [23:0] mb;
        int          ea;
        int          eb;
        int          d;
        logic [63:0] x;
        logic [63:0] y;
        logic        lost;
        if (is_nan(a))
            return a | QUIET_BIT;
        if (is_nan(b))
            return b | QUIET_BIT;
        if (is_inf(a))
        begin
            if (is_inf(b) && a[31] != b[31])
                return DEFAULT_NAN;
            return a;
        end
        if (is_inf(b))
            return b;
        if (is_zero(a) && is_zero(b))
            return {a[31] & b[31], 31'd0};
        if (is_zero(a))
            return b;
        if (is_zero(b))
            return a;
        if (exp_of(a) < exp_of(b))
        begin
            sa = b[31]; ma = mant_of(b); ea = exp_of(b);
            sb = a[31]; mb = mant_of(a); eb = exp_of(a);
        end
        else
        begin
            sa = a[31]; ma = mant_of(a); ea = exp_of(a);
            sb = b[31]; mb = mant_of(b); eb = exp_of(b);
        end
        d = ea - eb;
        x = 64'(ma) << 26;
        y = 64'(mb) << 26;
        if (d >= 60)
        begin
            y = 64'd1;
        end
        else if (d > 0)
        begin
            lost = (y & ((64'd1 << d) - 64'd1)) != 64'd0;
            y    = (y >> d) | 64'(lost);
        end
        if (sa == sb)
            return round_pack(sa, x + y, ea - 26);
        if (x == y)
            return 32'd0;
        if (x > y)
            return round_pack(sa, x - y, ea - 26);
        return round_pack(sb, y - x, ea - 26);
    endfunction

    function automatic logic [31:0] fsub(input logic [31:0] a, input logic [31:0] b);
        if (is_nan(b))
            return fadd(a, b);
        return fadd(a, b ^ SIGN_BIT);
    endfunction

    function automatic logic [15:0] to_bf16(input logic [31:0] x);
        logic [31:0] t;
        t = x + 32'h0000_7FFF + 32'(x[16]);
        if (is_nan(x))
            return BF16_NAN;
        return t[31:16];
    endfunction

endpackage

@@ rtl/sgd_momentum_update_core.sv @@
`timescale 1ns / 1ps
// SGD optimizer update with momentum, Nesterov step and weight decay, fp32.
// Configuration: write cfg_data to register cfg_index while cfg_write is high
// (momentum, rate, decay, dampening, nesterov, gradient format). Write only
// while no item is in flight.
// Input: an item transfers on a clock edge with start high and busy low.
// busy is always low, so one item can be taken every cycle.
// Output: each result appears on result for one cycle with done high,
// once its item has passed through the stage registers s1 to s8, in order. The receiver cannot
// hold results off; results are never held back.
// The pipeline is a chain of eight fp32 operations (multiply, add,
// multiply, add, multiply, add, multiply, subtract), one register stage each.
// Throughput: one item per cycle.
// Reset clears the stage valid bits and all configuration registers to zero;
// items in flight are dropped.
module sgd_momentum_update_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [sgdm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic                         start,
    output logic                         busy,
    input  sgdm_pkg::sgdm_in_t           item,
    output logic                         done,
    output sgdm_pkg::sgdm_out_t          result
);
    import sgdm_pkg::*;

    logic [31:0] mom_reg, rate_reg, decay_reg, damp_reg;
    logic        nest_reg, gfmt_reg;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic        mom_off;

    logic [31:0] s1_p_reg, s1_g_reg, s1_v_reg, s1_a_reg, s1_gw_reg;
    logic [31:0] s2_p_reg, s2_v_reg, s2_g_reg, s2_gw_reg;
    logic [31:0] s3_p_reg, s3_v_reg, s3_g_reg, s3_vm_reg, s3_gg_reg;
    logic [31:0] s4_p_reg, s4_v_reg, s4_g_reg, s4_nv_reg;
    logic [31:0] s5_p_reg, s5_v_reg, s5_g_reg, s5_nv_reg, s5_t_reg;
    logic [31:0] s6_p_reg, s6_step_reg, s6_nv_reg;
    logic [31:0] s7_p_reg, s7_x_reg, s7_nv_reg;
    logic [31:0] s8_np_reg, s8_nv_reg;
    logic [15:0] s8_bf_reg;
    logic [31:0] g_in;
    logic [31:0] s6_g2;
    logic [31:0] s8_np_next;

    assign busy    = 1'b0;
    assign mom_off = is_zero(mom_reg);
    assign g_in    = gfmt_reg ? {item.grad_bits[15:0], 16'd0} : item.grad_bits;
    assign s6_g2   = fadd(s5_g_reg, s5_t_reg);
    assign s8_np_next = fsub(s7_p_reg, s7_x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mom_reg   <= '0;
            rate_reg  <= '0;
            decay_reg <= '0;
            damp_reg  <= '0;
            nest_reg  <= 1'b0;
            gfmt_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MOMENTUM:  mom_reg   <= cfg_data;
                REG_RATE:      rate_reg  <= cfg_data;
                REG_DECAY:     decay_reg <= cfg_data;
                REG_DAMPENING: damp_reg  <= cfg_data;
                REG_NESTEROV:  nest_reg  <= cfg_data[0];
                REG_GRAD_FMT:  gfmt_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], start & ~busy};
    end

    always_ff @(posedge clk)
    begin
        s1_p_reg  <= item.param_bits;
        s1_g_reg  <= g_in;
        s1_v_reg  <= item.momentum_in;
        s1_a_reg  <= fmul(item.param_bits, decay_reg);
        s1_gw_reg <= fsub(FP_ONE, damp_reg);

        s2_p_reg  <= s1_p_reg;
        s2_v_reg  <= s1_v_reg;
        s2_gw_reg <= s1_gw_reg;
        s2_g_reg  <= fadd(s1_g_reg, s1_a_reg);

        s3_p_reg  <= s2_p_reg;
        s3_v_reg  <= s2_v_reg;
        s3_g_reg  <= s2_g_reg;
        s3_vm_reg <= fmul(s2_v_reg, mom_reg);
        s3_gg_reg <= fmul(s2_g_reg, s2_gw_reg);

        s4_p_reg  <= s3_p_reg;
        s4_v_reg  <= s3_v_reg;
        s4_g_reg  <= s3_g_reg;
        s4_nv_reg <= fadd(s3_vm_reg, s3_gg_reg);

        s5_p_reg  <= s4_p_reg;
        s5_v_reg  <= s4_v_reg;
        s5_g_reg  <= s4_g_reg;
        s5_nv_reg <= s4_nv_reg;
        s5_t_reg  <= fmul(s4_nv_reg, mom_reg);

        s6_p_reg  <= s5_p_reg;
        s6_nv_reg <= mom_off ? s5_v_reg : s5_nv_reg;
        if (mom_off)
            s6_step_reg <= s5_g_reg;
        else if (nest_reg)
            s6_step_reg <= s6_g2;
        else
            s6_step_reg <= s5_nv_reg;

        s7_p_reg  <= s6_p_reg;
        s7_nv_reg <= s6_nv_reg;
        s7_x_reg  <= fmul(s6_step_reg, rate_reg);

        s8_np_reg <= s8_np_next;
        s8_nv_reg <= s7_nv_reg;
        s8_bf_reg <= to_bf16(s8_np_next);
    end

    assign done                     = vld_reg[PIPE_DEPTH-1];
    assign result.new_param_bits    = s8_np_reg;
    assign result.new_momentum_bits = s8_nv_reg;
    assign result.param_bf16_copy   = s8_bf_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##8 done)
        else $error("accepted item produced no result");

    a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 8))
        else $error("result without accepted item");

    a_bf16_nan: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_nan(result.new_param_bits)) |-> (result.param_bf16_copy == BF16_NAN))
        else $error("bf16 copy of NaN parameter wrong");

endmodule

@@ dv/sgd_momentum_update_checker.sv @@
`timescale 1ns / 1ps
module sgd_momentum_update_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [sgdm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           start,
    input  logic                           busy,
    input  sgdm_pkg::sgdm_in_t             item,
    input  logic                           done,
    input  sgdm_pkg::sgdm_out_t            result,
    output int                             fail_count,
    output int                             pending
);
    import sgdm_pkg::*;

    localparam logic [31:0] ONE_F32 = 32'h3F80_0000;
    localparam logic [31:0] SIGN_M  = 32'h8000_0000;
    localparam logic [31:0] QNAN_M  = 32'h0040_0000;
    localparam logic [31:0] DNAN    = 32'hFFC0_0000;
    localparam logic [31:0] INF_P   = 32'h7F80_0000;

    logic [31:0] mom_q;
    logic [31:0] rate_q;
    logic [31:0] decay_q;
    logic [31:0] damp_q;
    logic        nest_q;
    logic        bf16_grad_q;
    sgdm_out_t   update_q[$];

    function automatic logic nan_f(input logic [31:0] a);
        return a[30:0] > 31'h7F80_0000;
    endfunction

    function automatic logic inf_f(input logic [31:0] a);
        return a[30:0] == 31'h7F80_0000;
    endfunction

    function automatic logic zero_f(input logic [31:0] a);
        return a[30:0] == 31'd0;
    endfunction

    function automatic logic [63:0] sig_f(input logic [31:0] a);
        return (a[30:23] == 8'd0) ? 64'(a[22:0]) : 64'({1'b1, a[22:0]});
    endfunction

    function automatic int scale_f(input logic [31:0] a);
        return (a[30:23] == 8'd0) ? -149 : int'(a[30:23]) - 150;
    endfunction

    function automatic logic [31:0] rne_pack(input logic s, input logic [63:0] m, input int e);
        int          msb;
        int          be;
        int          sh;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] h;
        logic [63:0] w;
        msb = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (m[i])
                msb = i;
        end
        be = msb + e + 127;
        sh = (be >= 1) ? msb - 23 : -149 - e;
        if (sh <= 0)
        begin
            q = m << (-sh);
        end
        else if (sh > 60)
        begin
            q = 64'd0;
        end
        else
        begin
            q = m >> sh;
            r = m & ((64'd1 << sh) - 64'd1);
            h = 64'd1 << (sh - 1);
            if (r > h || (r == h && q[0]))
                q = q + 64'd1;
        end
        if (be >= 1)
        begin
            w = (64'(be - 1) << 23) + q;
            if (w >= 64'(INF_P))
                w = 64'(INF_P);
        end
        else
        begin
            w = q;
        end
        return {s, 31'd0} | w[31:0];
    endfunction

    function automatic logic [31:0] mul_f(input logic [31:0] a, input logic [31:0] b);
        logic s;
        s = a[31] ^ b[31];
        if (nan_f(a))
            return a | QNAN_M;
        if (nan_f(b))
            return b | QNAN_M;
        if (inf_f(a) || inf_f(b))
            return (zero_f(a) || zero_f(b)) ? DNAN : ({s, 31'd0} | INF_P);
        if (zero_f(a) || zero_f(b))
            return {s, 31'd0};
        return rne_pack(s, sig_f(a) * sig_f(b), scale_f(a) + scale_f(b));
    endfunction

    function automatic logic [31:0] add_f(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] hi;
        logic [31:0] lo;
        logic [63:0] x;
        logic [63:0] y;
        int          d;
        logic        sticky;
        if (nan_f(a))
            return a | QNAN_M;
        if (nan_f(b))
            return b | QNAN_M;
        if (inf_f(a))
            return (inf_f(b) && a[31] != b[31]) ? DNAN : a;
        if (inf_f(b))
            return b;
        if (zero_f(a) && zero_f(b))
            return {a[31] & b[31], 31'd0};
        if (zero_f(a))
            return b;
        if (zero_f(b))
            return a;
        if (scale_f(a) < scale_f(b))
        begin
            hi = b;
            lo = a;
        end
        else
        begin
            hi = a;
            lo = b;
        end
        d = scale_f(hi) - scale_f(lo);
        x = sig_f(hi) << 26;
        y = sig_f(lo) << 26;
        if (d >= 60)
        begin
            y = 64'd1;
        end
        else if (d > 0)
        begin
            sticky = (y & ((64'd1 << d) - 64'd1)) != 64'd0;
            y = (y >> d) | 64'(sticky);
        end
        if (hi[31] == lo[31])
            return rne_pack(hi[31], x + y, scale_f(hi) - 26);
        if (x == y)
            return 32'd0;
        if (x > y)
            return rne_pack(hi[31], x - y, scale_f(hi) - 26);
        return rne_pack(lo[31], y - x, scale_f(hi) - 26);
    endfunction

    function automatic logic [31:0] sub_f(input logic [31:0] a, input logic [31:0] b);
        return nan_f(b) ? add_f(a, b) : add_f(a, b ^ SIGN_M);
    endfunction

    function automatic logic [15:0] bf16_rne(input logic [31:0] x);
        logic [31:0] t;
        if (nan_f(x))
            return 16'h7FC0;
        t = x + 32'h0000_7FFF + 32'(x[16]);
        return t[31:16];
    endfunction

    function automatic sgdm_out_t predict_update(input sgdm_in_t it);
        sgdm_out_t   o;
        logic [31:0] g;
        logic [31:0] v;
        g = bf16_grad_q ? {it.grad_bits[15:0], 16'd0} : it.grad_bits;
        g = add_f(g, mul_f(it.param_bits, decay_q));
        v = it.momentum_in;
        if (mom_q[30:0] != 31'd0)
        begin
            v = add_f(mul_f(it.momentum_in, mom_q), mul_f(g, sub_f(ONE_F32, damp_q)));
            g = nest_q ? add_f(g, mul_f(v, mom_q)) : v;
        end
        o.new_param_bits    = sub_f(it.param_bits, mul_f(g, rate_q));
        o.new_momentum_bits = v;
        o.param_bf16_copy   = bf16_rne(o.new_param_bits);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sgdm_out_t want;
        if (!rst_n)
        begin
            mom_q       <= '0;
            rate_q      <= '0;
            decay_q     <= '0;
            damp_q      <= '0;
            nest_q      <= 1'b0;
            bf16_grad_q <= 1'b0;
            fail_count  <= 0;
            pending     <= 0;
            update_q.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_MOMENTUM:  mom_q       <= cfg_data;
                    REG_RATE:      rate_q      <= cfg_data;
                    REG_DECAY:     decay_q     <= cfg_data;
                    REG_DAMPENING: damp_q      <= cfg_data;
                    REG_NESTEROV:  nest_q      <= cfg_data[0];
                    REG_GRAD_FMT:  bf16_grad_q <= cfg_data[0];
                    default: ;
                endcase
            end
            if (done)
            begin
                if (update_q.size() == 0)
                begin
                    $error("unexpected result transfer %h", result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = update_q.pop_front();
                    if (result.new_param_bits !== want.new_param_bits)
                        $error("new_param_bits: expected %h actual %h",
                               want.new_param_bits, result.new_param_bits);
                    if (result.new_momentum_bits !== want.new_momentum_bits)
                        $error("new_momentum_bits: expected %h actual %h",
                               want.new_momentum_bits, result.new_momentum_bits);
                    if (result.param_bf16_copy !== want.param_bf16_copy)
                        $error("param_bf16_copy: expected %h actual %h",
                               want.param_bf16_copy, result.param_bf16_copy);
                    if (result !== want)
                        fail_count <= fail_count + 1;
                end
            end
            if (start && !busy)
                update_q.push_back(predict_update(item));
            pending <= update_q.size();
        end
    end

endmodule

@@ dv/sgd_momentum_update_core_tb.sv @@
`timescale 1ns / 1ps
module sgd_momentum_update_core_tb;
    import sgdm_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 start;
    logic                 busy;
    sgdm_in_t             item;
    logic                 done;
    sgdm_out_t            result;
    int                   fail_count;
    int                   pending;

    sgd_momentum_update_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .item(item),
        .done(done), .result(result)
    );

    sgd_momentum_update_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] pick_f32();
        logic [31:0] x;
        x = $urandom();
        case ($urandom_range(0, 11))
            0: x[30:23] = 8'hFF;
            1: x[30:23] = 8'h00;
            2: x[30:0] = 31'd0;
            3: x[30:23] = 8'($urandom_range(1, 30));
            4: x[30:23] = 8'($urandom_range(225, 254));
            default: x[30:23] = 8'($urandom_range(100, 150));
        endcase
        return x;
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic drain_pipe();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic load_settings(input logic [31:0] mom, input logic [31:0] rate,
                                 input logic [31:0] dec, input logic [31:0] damp,
                                 input logic nest, input logic fmt);
        drain_pipe();
        write_reg(REG_MOMENTUM, mom);
        write_reg(REG_RATE, rate);
        write_reg(REG_DECAY, dec);
        write_reg(REG_DAMPENING, damp);
        write_reg(REG_NESTEROV, {31'($urandom()) , nest});
        write_reg(REG_GRAD_FMT, {31'($urandom()), fmt});
        cfg_write <= 1'b0;
    endtask

    task automatic send_item(input logic [31:0] p, input logic [31:0] g,
                             input logic [31:0] v);
        start <= 1'b1;
        item  <= '{param_bits: p, grad_bits: g, momentum_in: v};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_burst(input int count);
        int burst;
        int sent;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 20);
            while (burst > 0 && sent < count)
            begin
                send_item(pick_f32(), pick_f32(), pick_f32());
                burst--;
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("sgd_momentum_update_core: mismatch");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        start     = 1'b0;
        item      = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(32'h3F80_0000, 32'h3F00_0000, 32'h0);
        load_settings(32'h3F66_6666, 32'h3C23_D70A, 32'h3727_C5AC, 32'h0, 1'b0, 1'b0);
        send_item(32'h0000_0000, 32'h8000_0000, 32'h7F80_0000);
        send_item(32'h7F80_0000, 32'h3F80_0000, 32'h0);
        send_item(32'h7FA0_0001, 32'h7FC0_1234, 32'hFF80_0000);
        send_item(32'h3F80_0000, 32'hFFA0_0000, 32'h0000_0001);
        send_item(32'h0000_0001, 32'h8000_0001, 32'h807F_FFFF);
        send_item(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F7F_FFFF);
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(32'h3F80_8000, 32'h0, 32'h0);
        send_item(32'h3F81_8000, 32'h0, 32'h0);
        load_settings(32'h8000_0000, 32'h7F80_0000, 32'h7F7F_FFFF, 32'h3F80_0000, 1'b1, 1'b1);
        send_item(32'h3F80_0000, 32'hFFFF_3F80, 32'h4000_0000);
        send_item(32'h0, 32'h0000_7FC1, 32'h0);
        send_item(32'h8000_0000, 32'h0000_8000, 32'h0);
        load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
        send_item(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000);
        load_settings(32'h3F00_0000, 32'h3F80_0000, 32'h0, 32'h3E80_0000, 1'b1, 1'b1);
        send_item(32'h4000_0000, 32'hABCD_C000, 32'h3F80_0000);
        send_item(32'h7F80_0000, 32'h0000_FF80, 32'hFF80_0000);

        for (int phase = 0; phase < 8; phase++)
        begin
            load_settings(($urandom_range(0, 3) == 0) ? 32'h0 : pick_f32(),
                          pick_f32(), pick_f32(), pick_f32(),
                          1'($urandom()), 1'($urandom()));
            send_burst(50);
        end

        drain_pipe();
        if (fail_count == 0)
            $display("sgd_momentum_update_core: match");
        else
            $display("sgd_momentum_update_core: mismatch");
        $finish;
    end

endmodule
